>>> src/rwstm_pkg.sv
// ----------------------------------------------------------------------------
// rwstm_pkg
// Shared constants, codes and the result bundle of the random-walk maze unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rwstm_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int DIM_W     = SIDE_W + 1;
  localparam int CELL_W    = 2 * SIDE_W;
  localparam int MAP_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int EPOCH_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DIM_W;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW   = 2'd3;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [2:0] DIR_NORTH = 3'd0;
  localparam logic [2:0] DIR_SOUTH = 3'd1;
  localparam logic [2:0] DIR_WEST  = 3'd2;
  localparam logic [2:0] DIR_EAST  = 3'd3;

  typedef struct packed {
    logic              done_res;
    logic [CELL_W-1:0] cells_left;
    logic [SIDE_W-1:0] to_row;
    logic [SIDE_W-1:0] to_col;
    logic [SIDE_W-1:0] from_row;
    logic [SIDE_W-1:0] from_col;
    logic              carved;
    logic              moved;
  } rwstm_res_t;

endpackage

`default_nettype wire

>>> src/random_walk_spanning_tree_maze_unit.sv
// ----------------------------------------------------------------------------
// random_walk_spanning_tree_maze_unit
// Random-walk spanning-tree maze carver on a grid of up to 64 x 64 cells.
// ----------------------------------------------------------------------------
// Input words carry an operation in s_tuser (restart or step) and a step
// direction in s_tdata. Every accepted word gives exactly one output word
// with the move, the carved edge, the cells left and the done flag.
// Configuration (grid size, start cell) is written through cfg_we/cfg_index/
// cfg_data and takes effect at the next restart.
// Each word is accepted in the idle state, then either the visited-tag check
// and write-back of the new cell, or the report, follows. The visited map is
// a 4096-entry tag RAM with a registered read; a word is accepted only while
// the sequencer is idle. Restart bumps a 4-bit epoch instead of clearing the map.
// After reset, and on the 16th restart and every 15th one after it, a
// clearing pass runs over all 4096 entries of the RAM; s_tready stays low
// meanwhile, config writes still land.
// The result sits in an output register; a word is accepted while that
// register is empty or being drained, so a stalled receiver holds m_tvalid
// and m_tdata steady and back-pressures the input after one word.
// After reset the walk counts as done: steps report done until a restart.
// ----------------------------------------------------------------------------
`default_nettype none

module random_walk_spanning_tree_maze_unit
  import rwstm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [2:0] step_direction
  input  wire logic [0:0]           s_tuser,   // [0] operation
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [39:0]          m_tdata    // [0] moved, [1] carved,
                                               // [7:2] from_col, [13:8] from_row,
                                               // [19:14] to_col, [25:20] to_row,
                                               // [37:26] cells_left, [38] done_res
);

  logic               slot_free;
  logic               res_push;
  rwstm_res_t         res;
  logic               ram_we;
  logic [CELL_W-1:0]  ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic               ram_re;
  logic [CELL_W-1:0]  ram_raddr;
  logic [EPOCH_W-1:0] ram_rdata;

  assign slot_free = !m_tvalid || m_tready;

  rwstm_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[0]),
    .in_dir    (s_tdata[2:0]),
    .slot_free (slot_free),
    .res_push  (res_push),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rwstm_tag_ram u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      m_tdata <= {1'b0, res};
    end
  end

endmodule

`default_nettype wire

>>> src/rwstm_tag_ram.sv
// ----------------------------------------------------------------------------
// rwstm_tag_ram
// Visited map: one epoch tag per cell, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rwstm_tag_ram
  import rwstm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [CELL_W-1:0]  waddr,
  input  wire logic [EPOCH_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [CELL_W-1:0]  raddr,
  output logic      [EPOCH_W-1:0] rdata
);

  logic [EPOCH_W-1:0] mem [0:MAP_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/rwstm_walker.sv
// ----------------------------------------------------------------------------
// rwstm_walker
// Walker sequencer: config registers, move check, visited read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module rwstm_walker
  import rwstm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [2:0]           in_dir,
  input  wire logic                 slot_free,
  output logic                      res_push,
  output rwstm_res_t                res,
  output logic                      ram_we,
  output logic      [CELL_W-1:0]    ram_waddr,
  output logic      [EPOCH_W-1:0]   ram_wdata,
  output logic                      ram_re,
  output logic      [CELL_W-1:0]    ram_raddr,
  input  wire logic [EPOCH_W-1:0]   ram_rdata
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_REPORT
  } state_t;

  state_t             state;
  logic [DIM_W-1:0]   grid_width;
  logic [DIM_W-1:0]   grid_height;
  logic [SIDE_W-1:0]  start_col;
  logic [SIDE_W-1:0]  start_row;
  logic [DIM_W-1:0]   act_w;
  logic [DIM_W-1:0]   act_h;
  logic [SIDE_W-1:0]  walker_col;
  logic [SIDE_W-1:0]  walker_row;
  logic [SIDE_W-1:0]  next_col;
  logic [SIDE_W-1:0]  next_row;
  logic [CELL_W-1:0]  unvisited;
  logic [EPOCH_W-1:0] epoch;
  logic [CELL_W-1:0]  clr_cnt;
  logic               restart_pend;

  logic [DIM_W-1:0]   cw;
  logic [DIM_W-1:0]   ch;
  logic [SIDE_W-1:0]  sc;
  logic [SIDE_W-1:0]  sr;
  logic [2*DIM_W-1:0] area;
  logic [2*DIM_W-1:0] area_m1;
  logic               ok;
  logic [SIDE_W-1:0]  nc;
  logic [SIDE_W-1:0]  nr;
  logic               accept;
  logic               can_step;
  logic               visited;

  always_comb begin
    cw = grid_width;
    if (grid_width == '0) cw = DIM_W'(1);
    else if (grid_width > DIM_W'(MAX_SIDE)) cw = DIM_W'(MAX_SIDE);
    ch = grid_height;
    if (grid_height == '0) ch = DIM_W'(1);
    else if (grid_height > DIM_W'(MAX_SIDE)) ch = DIM_W'(MAX_SIDE);
    sc = ({1'b0, start_col} < cw) ? start_col : SIDE_W'(cw - DIM_W'(1));
    sr = ({1'b0, start_row} < ch) ? start_row : SIDE_W'(ch - DIM_W'(1));
    area    = (2*DIM_W)'(cw) * (2*DIM_W)'(ch);
    area_m1 = area - (2*DIM_W)'(1);

    ok = 1'b0;
    nc = walker_col;
    nr = walker_row;
    case (in_dir)
      DIR_NORTH: begin
        ok = (walker_row != '0);
        nr = walker_row - SIDE_W'(1);
      end
      DIR_SOUTH: begin
        ok = ({1'b0, walker_row} + DIM_W'(1)) < act_h;
        nr = walker_row + SIDE_W'(1);
      end
      DIR_WEST: begin
        ok = (walker_col != '0);
        nc = walker_col - SIDE_W'(1);
      end
      DIR_EAST: begin
        ok = ({1'b0, walker_col} + DIM_W'(1)) < act_w;
        nc = walker_col + SIDE_W'(1);
      end
      default: ok = 1'b0;
    endcase

    in_ready = (state == ST_IDLE) && slot_free;
    accept   = in_valid && in_ready;
    can_step = (in_op == OP_STEP) && (unvisited != '0) && ok;
    visited  = (ram_rdata == epoch);

    ram_re    = accept && can_step;
    ram_raddr = {nr, nc};

    ram_we    = 1'b0;
    ram_waddr = {walker_row, walker_col};
    ram_wdata = epoch;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_START: ram_we = 1'b1;
      ST_CHECK: begin
        ram_we    = !visited;
        ram_waddr = {next_row, next_col};
      end
      default: ram_we = 1'b0;
    endcase

    res_push       = (state == ST_START) || (state == ST_CHECK) || (state == ST_REPORT);
    res.moved      = (state == ST_CHECK);
    res.carved     = (state == ST_CHECK) && !visited;
    res.from_col   = walker_col;
    res.from_row   = walker_row;
    res.to_col     = (state == ST_CHECK) ? next_col : walker_col;
    res.to_row     = (state == ST_CHECK) ? next_row : walker_row;
    res.cells_left = res.carved ? unvisited - CELL_W'(1) : unvisited;
    res.done_res   = (res.cells_left == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      grid_width   <= DIM_W'(16);
      grid_height  <= DIM_W'(16);
      start_col    <= '0;
      start_row    <= '0;
      act_w        <= DIM_W'(1);
      act_h        <= DIM_W'(1);
      walker_col   <= '0;
      walker_row   <= '0;
      unvisited    <= '0;
      epoch        <= '0;
      clr_cnt      <= '0;
      restart_pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          REG_START_COL:   start_col   <= cfg_data[SIDE_W-1:0];
          REG_START_ROW:   start_row   <= cfg_data[SIDE_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CELL_W'(1);
          if (clr_cnt == CELL_W'(MAP_DEPTH - 1)) begin
            restart_pend <= 1'b0;
            state        <= restart_pend ? ST_START : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_op == OP_RESTART) begin
              act_w      <= cw;
              act_h      <= ch;
              walker_col <= sc;
              walker_row <= sr;
              unvisited  <= area_m1[CELL_W-1:0];
              if (epoch == EPOCH_MAX) begin
                epoch        <= EPOCH_W'(1);
                clr_cnt      <= '0;
                restart_pend <= 1'b1;
                state        <= ST_CLEAR;
              end else begin
                epoch <= epoch + EPOCH_W'(1);
                state <= ST_START;
              end
            end else if (can_step) begin
              next_col <= nc;
              next_row <= nr;
              state    <= ST_CHECK;
            end else begin
              state <= ST_REPORT;
            end
          end
        end
        ST_CHECK: begin
          walker_col <= next_col;
          walker_row <= next_row;
          unvisited  <= res.cells_left;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/rwstm_checker.sv
// ----------------------------------------------------------------------------
// rwstm_checker
// Port-level checks of the maze unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rwstm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_carve_moves: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("carved without a move");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[38] == (m_tdata[37:26] == 12'd0)))
    else $error("done flag disagrees with cells left");

  a_still_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[7:2] == m_tdata[19:14]) &&
                                (m_tdata[13:8] == m_tdata[25:20]))
    else $error("walker cell changed without a move");

endmodule

bind random_walk_spanning_tree_maze_unit rwstm_checker u_rwstm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
